// File: rtl/apsu_pkg.sv
// Shared types, constants and palette functions of the attribute pixel serializer.
// No dependencies; every module of the block imports this package.
package apsu_pkg;

    localparam int PIXELS      = 8;
    localparam int CNT_W       = $clog2(PIXELS);
    localparam int PEN_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic CMD_BLINK = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH    = 1'b1;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PIXELS - 1);

    typedef struct packed {
        logic       command;
        logic       line_level;
        logic [7:0] attribute_byte;
        logic [7:0] graphics_byte;
    } t_in_item;

    typedef struct packed {
        logic [PEN_W-1:0] pen;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             last_pixel;
    } t_out_item;

    typedef struct packed {
        logic high_resolution;
        logic flash_enable;
    } t_cfg;

    // One classified cell as it waits between the front and the back.
    typedef struct packed {
        logic             hires;
        logic [7:0]       attr;
        logic [7:0]       gfx;
        logic [PEN_W-1:0] fg;
        logic [PEN_W-1:0] bg;
    } t_cell;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic logic [PEN_W-1:0] hires_pen(input logic [1:0] sel);
        logic [PEN_W-1:0] pen;
        unique case (sel)
            2'd0: pen = 5'd0;
            2'd1: pen = 5'd2;
            2'd2: pen = 5'd5;
            2'd3: pen = 5'd7;
            default: pen = 5'd0;
        endcase
        return pen;
    endfunction

    function automatic t_rgb palette(input logic [PEN_W-1:0] pen);
        t_rgb c;
        unique case (pen)
            5'd0:  c = '{8'h00, 8'h00, 8'h00};
            5'd1:  c = '{8'h00, 8'h00, 8'hd0};
            5'd2:  c = '{8'hd0, 8'h00, 8'h00};
            5'd3:  c = '{8'hd0, 8'h00, 8'hd0};
            5'd4:  c = '{8'h00, 8'hd0, 8'h00};
            5'd5:  c = '{8'h00, 8'hd0, 8'hd0};
            5'd6:  c = '{8'hd0, 8'hd0, 8'h00};
            5'd7:  c = '{8'hd0, 8'hd0, 8'hd0};
            5'd8:  c = '{8'h00, 8'h00, 8'h00};
            5'd9:  c = '{8'h60, 8'h00, 8'ha0};
            5'd10: c = '{8'ha0, 8'h60, 8'h00};
            5'd11: c = '{8'ha0, 8'h00, 8'h60};
            5'd12: c = '{8'h00, 8'ha0, 8'h60};
            5'd13: c = '{8'h00, 8'h60, 8'ha0};
            5'd14: c = '{8'ha0, 8'ha0, 8'h60};
            5'd15: c = '{8'hd0, 8'hd0, 8'hd0};
            5'd16: c = '{8'h00, 8'h00, 8'h00};
            5'd17: c = '{8'h00, 8'h00, 8'ha0};
            5'd18: c = '{8'ha0, 8'h00, 8'h00};
            5'd19: c = '{8'ha0, 8'h00, 8'ha0};
            5'd20: c = '{8'h00, 8'ha0, 8'h00};
            5'd21: c = '{8'h00, 8'ha0, 8'ha0};
            5'd22: c = '{8'ha0, 8'ha0, 8'h00};
            5'd23: c = '{8'ha0, 8'ha0, 8'ha0};
            default: c = '{8'h00, 8'h00, 8'h00};
        endcase
        return c;
    endfunction

endpackage

// File: rtl/apsu_front.sv
// Front end: configuration registers, blink phase and classification of draw items.
// Depends on apsu_pkg; pushes classified cells into apsu_queue.
module apsu_front
    import apsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cell                o_cell
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic r_phase;
    logic n_phase;
    logic accept;

    function automatic logic [PEN_W-1:0] BG_PEN_BASE_PEN(input logic [2:0] ink);
        return PEN_W'(16) | PEN_W'(ink);
    endfunction

    assign o_stall     = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !i_q_full;
    assign o_push      = accept && (i_item.command == CMD_DRAW);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HIGH_RES: n_cfg.high_resolution = i_cfg_data;
                CFG_FLASH:    n_cfg.flash_enable    = i_cfg_data;
                default:      n_cfg = r_cfg;
            endcase
        end
        n_phase = r_phase;
        if (accept && (i_item.command == CMD_BLINK) && i_item.line_level) begin
            n_phase = !r_phase;
        end
    end

    // Low-resolution pens are resolved here so the back end only selects per pixel.
    always_comb begin
        o_cell.hires = r_cfg.high_resolution;
        o_cell.attr  = i_item.attribute_byte;
        o_cell.gfx   = i_item.graphics_byte;
        o_cell.bg    = BG_PEN_BASE_PEN(i_item.attribute_byte[2:0]);
        o_cell.fg    = {1'b0, i_item.attribute_byte[6:3]};
        if (i_item.attribute_byte[7] && r_phase && r_cfg.flash_enable) begin
            o_cell.fg = o_cell.bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_cfg   <= n_cfg;
            r_phase <= n_phase;
        end
    end

endmodule

// File: rtl/apsu_queue.sv
// Short queue of classified cells between the front and the back end.
// Depends on apsu_pkg.
module apsu_queue
    import apsu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cell i_cell,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_nonempty,
    output t_cell o_cell
);

    t_cell              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_count;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_cell     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("cell queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("cell pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_nonempty |-> !i_pop)
        else $error("cell popped from an empty queue");

endmodule

// File: rtl/apsu_back.sv
// Back end: shifts one cell out as eight pixels and registers pen and palette RGB.
// Depends on apsu_pkg; takes cells from apsu_queue.
module apsu_back
    import apsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_nonempty,
    input  t_cell     i_cell,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_pixel
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    t_cell            r_cell;
    logic             r_ovalid;
    t_out_item        r_opix;

    logic             out_free;
    logic             pix_go;
    logic             is_last;
    logic [PEN_W-1:0] pen;
    t_rgb             rgb;

    assign out_free = !r_ovalid || !i_stall;
    assign pix_go   = r_busy && out_free;
    assign is_last  = (r_cnt == LAST_CNT);
    // A new cell is loaded in the cycle the previous one sends its eighth pixel.
    assign o_pop    = i_q_nonempty && (!r_busy || (pix_go && is_last));

    always_comb begin
        if (r_cell.hires) begin
            pen = hires_pen({r_cell.attr[7], r_cell.gfx[7]});
        end else begin
            pen = r_cell.gfx[7] ? r_cell.fg : r_cell.bg;
        end
        rgb = palette(pen);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cell <= i_cell;
        end else if (pix_go) begin
            r_cell.gfx  <= {r_cell.gfx[6:0], 1'b0};
            r_cell.attr <= {r_cell.attr[6:0], 1'b0};
        end
        if (pix_go) begin
            r_opix.pen        <= pen;
            r_opix.red        <= rgb.red;
            r_opix.green      <= rgb.green;
            r_opix.blue       <= rgb.blue;
            r_opix.last_pixel <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (pix_go) begin
                r_cnt <= r_cnt + 1'b1;
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (pix_go) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_pixel = r_opix;

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == '0) || $past(pix_go))
        else $error("pixel counter left mid-cell while idle");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_go && is_last && !o_pop) |=> !r_busy)
        else $error("serializer stays busy after the eighth pixel");

endmodule

// File: rtl/attribute_pixel_serializer_unit.sv
// Top level of the attribute pixel serializer: front end, cell queue and back end.
// A draw item's first pixel passes the cell queue, the back-end cell register and the
// output register in that order. Throughput: one pixel per clock while cells are queued
// and i_stall is low, set by the back-end shift register; blink items give no pixel.
// Reset (i_rst_n, synchronous, active low) clears both configuration registers,
// the blink phase, the queue and all valid flags. Depends on apsu_pkg.
module attribute_pixel_serializer_unit
    import apsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_pixel,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    logic  q_full;
    logic  q_nonempty;
    logic  push;
    logic  pop;
    t_cell push_cell;
    t_cell head_cell;

    apsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cell      (push_cell)
    );

    apsu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cell     (push_cell),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_cell     (head_cell)
    );

    apsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_cell       (head_cell),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel      (o_pixel)
    );

endmodule

// File: dv/tb_attribute_pixel_serializer_unit.sv
// Testbench for attribute_pixel_serializer_unit: directed and random cells and blink events,
// predicted pixel by pixel and checked in order at the pixel output.
// Depends on apsu_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_attribute_pixel_serializer_unit;
    import apsu_pkg::*;

    localparam int ITEMS_PER_PHASE = 26;
    localparam int PHASES          = 8;
    localparam int SETTLE_CYCLES   = 10;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_in_item             i_item      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_out_item            o_pixel;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic                 i_cfg_data  = 1'b0;

    attribute_pixel_serializer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel     (o_pixel),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state: its own copy of the registers and the blink phase.
    logic        pred_high_res  = 1'b0;
    logic        pred_flash_en  = 1'b0;
    logic        pred_blink     = 1'b0;
    logic [23:0] pen_rgb [0:23];

    t_in_item    cell_queue[$];
    t_out_item   pixel_expect[$];
    int unsigned issued_cnt     = 0;
    int unsigned accepted_cnt   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;
    int unsigned error_count    = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Pens 0..7 and 16..23 follow the RGB bits of the pen index; 8..15 are irregular.
    initial begin
        for (int i = 0; i < 8; i++) begin
            pen_rgb[i]      = {i[1] ? 8'hd0 : 8'h00, i[2] ? 8'hd0 : 8'h00, i[0] ? 8'hd0 : 8'h00};
            pen_rgb[i + 16] = {i[1] ? 8'ha0 : 8'h00, i[2] ? 8'ha0 : 8'h00, i[0] ? 8'ha0 : 8'h00};
        end
        pen_rgb[8]  = 24'h000000;
        pen_rgb[9]  = 24'h6000a0;
        pen_rgb[10] = 24'ha06000;
        pen_rgb[11] = 24'ha00060;
        pen_rgb[12] = 24'h00a060;
        pen_rgb[13] = 24'h0060a0;
        pen_rgb[14] = 24'ha0a060;
        pen_rgb[15] = 24'hd0d0d0;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic t_in_item make_item(input logic cmd, input logic lvl,
                                           input logic [7:0] attr, input logic [7:0] gfx);
        t_in_item it;
        it.command        = cmd;
        it.line_level     = lvl;
        it.attribute_byte = attr;
        it.graphics_byte  = gfx;
        return it;
    endfunction

    // Works out the eight pixels of a draw item, or updates the blink phase.
    function automatic void predict_pixels(input t_in_item it);
        logic [4:0] fg;
        logic [4:0] bg;
        logic [4:0] pen;
        logic [1:0] sel;
        t_out_item  px;
        if (it.command == CMD_BLINK) begin
            if (it.line_level)
                pred_blink = ~pred_blink;
            return;
        end
        bg = {2'b10, it.attribute_byte[2:0]};
        fg = {1'b0, it.attribute_byte[6:3]};
        if (it.attribute_byte[7] && pred_blink && pred_flash_en)
            fg = bg;
        for (int k = 0; k < 8; k++) begin
            if (pred_high_res) begin
                sel = {it.attribute_byte[7 - k], it.graphics_byte[7 - k]};
                case (sel)
                    2'b00: pen = 5'd0;
                    2'b01: pen = 5'd2;
                    2'b10: pen = 5'd5;
                    default: pen = 5'd7;
                endcase
            end else begin
                pen = it.graphics_byte[7 - k] ? fg : bg;
            end
            px.pen        = pen;
            px.red        = pen_rgb[pen][23:16];
            px.green      = pen_rgb[pen][15:8];
            px.blue       = pen_rgb[pen][7:0];
            px.last_pixel = (k == 7);
            pixel_expect.push_back(px);
        end
    endfunction

    // Sender: a new item goes out only after the one on the bus has been taken.
    always @(negedge i_clk) begin
        logic     next_valid;
        t_in_item next_item;
        next_valid = 1'b0;
        next_item  = i_item;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (i_valid && accepted_cnt != issued_cnt) begin
            next_valid = 1'b1;
        end else if (cell_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_item  = cell_queue.pop_front();
            next_valid = 1'b1;
            issued_cnt++;
        end
        i_valid <= next_valid;
        i_item  <= next_item;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Input acceptance and pixel checking share one block so their order is fixed.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_pixels(i_item);
                accepted_cnt++;
            end
            if (o_valid && !i_stall) begin
                if (pixel_expect.size() == 0) begin
                    report_error($sformatf("pixel with nothing expected, pen %0d", o_pixel.pen));
                end else begin
                    want = pixel_expect.pop_front();
                    if (o_pixel.pen !== want.pen)
                        report_error($sformatf("pen got %0d want %0d", o_pixel.pen, want.pen));
                    if (o_pixel.red !== want.red)
                        report_error($sformatf("red got 0x%0h want 0x%0h", o_pixel.red, want.red));
                    if (o_pixel.green !== want.green)
                        report_error($sformatf("green got 0x%0h want 0x%0h",
                                               o_pixel.green, want.green));
                    if (o_pixel.blue !== want.blue)
                        report_error($sformatf("blue got 0x%0h want 0x%0h",
                                               o_pixel.blue, want.blue));
                    if (o_pixel.last_pixel !== want.last_pixel)
                        report_error($sformatf("last_pixel got %0b want %0b",
                                               o_pixel.last_pixel, want.last_pixel));
                end
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_HIGH_RES)
            pred_high_res = data;
        else if (idx == CFG_FLASH)
            pred_flash_en = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Blocks until every queued item is taken and every pixel has arrived.
    task automatic wait_drained(input int settle);
        while (cell_queue.size() != 0 || i_valid || pixel_expect.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin
        t_in_item    it;
        logic        hr_sel;
        logic        fe_sel;
        int unsigned mode;
        logic [7:0]  attr;
        logic [7:0]  gfx;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Low resolution, no flashing: extremes of both bytes and both blink levels.
        cfg_write(CFG_HIGH_RES, 1'b0);
        cfg_write(CFG_FLASH, 1'b0);
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'h00, 8'h00));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'hff, 8'hff));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'h7f, 8'haa));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b1, 8'h80, 8'h55));
        cell_queue.push_back(make_item(CMD_BLINK, 1'b0, 8'hff, 8'hff));
        cell_queue.push_back(make_item(CMD_BLINK, 1'b1, 8'h00, 8'h00));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'hff, 8'hf0));
        wait_drained(SETTLE_CYCLES);

        // Flashing enabled with the blink phase set: flashing cells lose the foreground.
        cfg_write(CFG_FLASH, 1'b1);
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'hff, 8'h0f));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'h7f, 8'hff));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b1, 8'h87, 8'h3c));
        cell_queue.push_back(make_item(CMD_BLINK, 1'b1, 8'h5a, 8'ha5));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'hff, 8'hff));
        wait_drained(SETTLE_CYCLES);

        // High resolution: all four pens; flashing must have no effect here.
        cfg_write(CFG_HIGH_RES, 1'b1);
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'h00, 8'h00));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'hff, 8'hff));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'hff, 8'h00));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b1, 8'h00, 8'hff));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'haa, 8'hcc));
        cell_queue.push_back(make_item(CMD_BLINK, 1'b1, 8'h00, 8'h00));
        cell_queue.push_back(make_item(CMD_DRAW, 1'b0, 8'h80, 8'h80));
        cell_queue.push_back(make_item(CMD_BLINK, 1'b1, 8'hff, 8'h00));
        wait_drained(SETTLE_CYCLES);
        cfg_write(CFG_FLASH, 1'b0);
        cell_queue.push_back(make_item(CMD_DRAW, 1'b1, 8'h5a, 8'ha5));
        wait_drained(SETTLE_CYCLES);

        // Random phases: every register setting, each under two of the four idling patterns.
        for (int p = 0; p < PHASES; p++) begin
            hr_sel = p[0] ^ p[2];
            fe_sel = p[1];
            cfg_write(CFG_HIGH_RES, hr_sel);
            cfg_write(CFG_FLASH, fe_sel);
            mode = p % 4;
            send_idle_pct = (mode == 1) ? 84 : (mode == 3) ? 24 : 0;
            stall_pct     = (mode == 2) ? 84 : (mode == 3) ? 24 : 0;
            for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
                attr = 8'($urandom_range(0, 255));
                gfx  = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0: gfx = 8'h00;
                    1: gfx = 8'hff;
                    default: ;
                endcase
                it = make_item(($urandom_range(0, 99) < 82) ? CMD_DRAW : CMD_BLINK,
                               1'($urandom_range(0, 1)), attr, gfx);
                cell_queue.push_back(it);
                // In phases 2 and 5 the test stops queueing halfway until every pixel is out.
                if (j == ITEMS_PER_PHASE / 2 && (p == 2 || p == 5))
                    wait_drained(0);
            end
            wait_drained(SETTLE_CYCLES);
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        wait_drained(SETTLE_CYCLES * 2);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
